// ----- rtl/crcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_pkg
// Shared types, constants and the CRC-8 bit step for the register frame parser.
// ----------------------------------------------------------------------------
package crcp_pkg;

    // burst limit for read frames
    localparam int unsigned MAX_BURST = 64;

    // field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ADDR_W = 7;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned CNT_W  = $clog2(MAX_BURST + 1);

    // apb port geometry
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // crc-8 atm generator
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

    // register indexes
    localparam logic [1:0] REG_SERVO = 2'd0;
    localparam logic [1:0] REG_MOTOR = 2'd1;
    localparam logic [1:0] REG_IMU   = 2'd2;

    // event kinds
    localparam logic EVT_READ  = 1'b0;
    localparam logic EVT_WRITE = 1'b1;

    // write action codes
    localparam logic [ACT_W-1:0] ACT_SERVO = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MOTOR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_IMU   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_OTHER = 2'd3;

    // configured register addresses
    typedef struct packed {
        logic [ADDR_W-1:0] servo_addr;
        logic [ADDR_W-1:0] motor_addr;
        logic [ADDR_W-1:0] imu_addr;
    } t_cfg;

    // control of the serial crc unit
    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } t_crc_ctl;

    // one result item
    typedef struct packed {
        logic                     event_kind;
        logic [ADDR_W-1:0]        reply_address;
        logic signed [DATA_W-1:0] reply_value;
        logic [ACT_W-1:0]         write_action;
        logic                     last_of_run;
    } t_evt;

    // one msb-first shift of the crc register
    function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] sh;
        sh = {c[BYTE_W-2:0], 1'b0};
        return c[BYTE_W-1] ? (sh ^ CRC_POLY) : sh;
    endfunction

endpackage

// ----- rtl/crcp_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_ifs
// Valid/ready channels: received bytes in, parser events out.
// ----------------------------------------------------------------------------
interface crcp_byte_if;
    import crcp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcp_evt_if;
    import crcp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     event_kind;
    logic [ADDR_W-1:0]        reply_address;
    logic signed [DATA_W-1:0] reply_value;
    logic [ACT_W-1:0]         write_action;
    logic                     last_of_run;

    modport source (output valid, output event_kind, output reply_address,
                    output reply_value, output write_action, output last_of_run,
                    input ready);
    modport sink   (input valid, input event_kind, input reply_address,
                    input reply_value, input write_action, input last_of_run,
                    output ready);
endinterface

// ----- rtl/crcp_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_cfg_regs
// APB register file holding the servo, motor and imu register addresses.
// ----------------------------------------------------------------------------
module crcp_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crcp_pkg::APB_AW-1:0]  paddr,
    input  logic [crcp_pkg::APB_DW-1:0]  pwdata,
    output logic [crcp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output crcp_pkg::t_cfg               o_cfg
);
    import crcp_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.servo_addr <= ADDR_W'(0);
            r_cfg.motor_addr <= ADDR_W'(1);
            r_cfg.imu_addr   <= ADDR_W'(2);
        end else if (w_wr) begin
            case (w_idx)
                REG_SERVO: r_cfg.servo_addr <= pwdata[ADDR_W-1:0];
                REG_MOTOR: r_cfg.motor_addr <= pwdata[ADDR_W-1:0];
                REG_IMU:   r_cfg.imu_addr   <= pwdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_SERVO: prdata = APB_DW'(r_cfg.servo_addr);
            REG_MOTOR: prdata = APB_DW'(r_cfg.motor_addr);
            REG_IMU:   prdata = APB_DW'(r_cfg.imu_addr);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// ----- rtl/crcp_crc8_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_crc8_unit
// Bit-serial CRC-8 register: xor a byte in, then one shift per cycle.
// ----------------------------------------------------------------------------
module crcp_crc8_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  crcp_pkg::t_crc_ctl          i_ctl,
    input  logic [crcp_pkg::BYTE_W-1:0] i_byte,
    output logic [crcp_pkg::BYTE_W-1:0] o_crc
);
    import crcp_pkg::*;

    logic [BYTE_W-1:0] r_crc;
    logic [BYTE_W-1:0] n_crc;

    // next crc value
    always_comb begin
        n_crc = r_crc;
        if (i_ctl.clear) begin
            n_crc = '0;
        end else if (i_ctl.load) begin
            n_crc = r_crc ^ i_byte;
        end else if (i_ctl.step) begin
            n_crc = crc_step(r_crc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;
endmodule

// ----- rtl/crcp_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_seq
// Frame sequencer: byte capture, crc check, shadow update, read burst and
// the output register.
// ----------------------------------------------------------------------------
module crcp_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  crcp_pkg::t_cfg              i_cfg,
    crcp_byte_if.sink                   rx,
    crcp_evt_if.source                  evt,
    output crcp_pkg::t_crc_ctl          o_crc_ctl,
    input  logic [crcp_pkg::BYTE_W-1:0] i_crc
);
    import crcp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CRC   = 4'b0010,
        S_WRITE = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    // frame phase codes
    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_DLO = 2'd1;
    localparam logic [1:0] PH_DHI = 2'd2;
    localparam logic [1:0] PH_CRC = 2'd3;

    t_state            r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [2:0]        r_bitc, n_bitc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_hdr, r_dlo, r_dhi;
    logic [BYTE_W-1:0] r_servo, n_servo;
    logic [DATA_W-1:0] r_motor, n_motor;
    logic              r_ovld, n_ovld;
    t_evt              r_evt, n_evt;

    logic              w_acc;
    logic              w_out_free;
    logic [CNT_W-1:0]  w_burst;
    logic [ACT_W-1:0]  w_act;
    logic [DATA_W-1:0] w_rd_value;
    logic [ADDR_W-1:0] w_waddr;

    assign rx.ready   = (r_state == S_IDLE);
    assign w_acc      = rx.valid && rx.ready;
    assign w_out_free = !r_ovld || evt.ready;
    assign w_waddr    = r_hdr[ADDR_W-1:0];

    // read count saturated at the burst limit
    assign w_burst = (r_dlo > BYTE_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                   : r_dlo[CNT_W-1:0];

    // write target decode, servo first, then motor, then imu
    always_comb begin
        if (w_waddr == i_cfg.servo_addr) begin
            w_act = ACT_SERVO;
        end else if (w_waddr == i_cfg.motor_addr) begin
            w_act = ACT_MOTOR;
        end else if (w_waddr == i_cfg.imu_addr) begin
            w_act = ACT_IMU;
        end else begin
            w_act = ACT_OTHER;
        end
    end

    // register read value for the current burst address
    always_comb begin
        if (r_addr == i_cfg.servo_addr) begin
            w_rd_value = {{(DATA_W-BYTE_W){r_servo[BYTE_W-1]}}, r_servo};
        end else if (r_addr == i_cfg.motor_addr) begin
            w_rd_value = r_motor;
        end else begin
            w_rd_value = '0;
        end
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_bitc    = r_bitc;
        n_cnt     = r_cnt;
        n_addr    = r_addr;
        n_servo   = r_servo;
        n_motor   = r_motor;
        n_ovld    = r_ovld && !evt.ready;
        n_evt     = r_evt;
        o_crc_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (r_phase != PH_CRC) begin
                        o_crc_ctl.load = 1'b1;
                        n_phase        = r_phase + 2'd1;
                        n_bitc         = '0;
                        n_state        = S_CRC;
                    end else begin
                        o_crc_ctl.clear = 1'b1;
                        n_phase         = PH_HDR;
                        if (i_crc == rx.rx_byte) begin
                            if (r_hdr[BYTE_W-1]) begin
                                if (w_burst != '0) begin
                                    n_cnt   = w_burst;
                                    n_addr  = r_hdr[ADDR_W-1:0];
                                    n_state = S_READ;
                                end
                            end else begin
                                n_state = S_WRITE;
                            end
                        end
                    end
                end
            end
            S_CRC: begin
                o_crc_ctl.step = 1'b1;
                n_bitc         = r_bitc + 3'd1;
                if (r_bitc == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_WRITE: begin
                if (w_out_free) begin
                    n_ovld              = 1'b1;
                    n_evt.event_kind    = EVT_WRITE;
                    n_evt.reply_address = w_waddr;
                    n_evt.reply_value   = $signed({r_dhi, r_dlo});
                    n_evt.write_action  = w_act;
                    n_evt.last_of_run   = 1'b1;
                    if (w_act == ACT_SERVO) begin
                        n_servo = r_dlo;
                    end else if (w_act == ACT_MOTOR) begin
                        n_motor = {r_dhi, r_dlo};
                    end
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_ovld              = 1'b1;
                    n_evt.event_kind    = EVT_READ;
                    n_evt.reply_address = r_addr;
                    n_evt.reply_value   = $signed(w_rd_value);
                    n_evt.write_action  = ACT_SERVO;
                    n_evt.last_of_run   = (r_cnt == CNT_W'(1));
                    n_cnt               = r_cnt - CNT_W'(1);
                    n_addr              = r_addr + ADDR_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_HDR;
            r_bitc  <= '0;
            r_cnt   <= '0;
            r_servo <= '0;
            r_motor <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bitc  <= n_bitc;
            r_cnt   <= n_cnt;
            r_servo <= n_servo;
            r_motor <= n_motor;
            r_ovld  <= n_ovld;
        end
    end

    // frame bytes, burst address and output payload
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_evt  <= n_evt;
        if (w_acc) begin
            case (r_phase)
                PH_HDR:  r_hdr <= rx.rx_byte;
                PH_DLO:  r_dlo <= rx.rx_byte;
                PH_DHI:  r_dhi <= rx.rx_byte;
                default: begin
                end
            endcase
        end
    end

    // output channel
    assign evt.valid         = r_ovld;
    assign evt.event_kind    = r_evt.event_kind;
    assign evt.reply_address = r_evt.reply_address;
    assign evt.reply_value   = r_evt.reply_value;
    assign evt.write_action  = r_evt.write_action;
    assign evt.last_of_run   = r_evt.last_of_run;
endmodule

// ----- rtl/crc_checked_register_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_register_frame_parser
// Register-access frame parser with CRC-8 check and servo/motor shadows.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per transfer. Four bytes form a frame:
//   header (bit 7 read flag, bits 6..0 address), data low, data high, and
//   a CRC-8 (poly 0x07, init 0) over the first three. Bad frames vanish.
//   o_evt carries one transfer per result: a write event, or one item per
//   register of a read burst (data low registers, at most MAX_BURST).
//   The APB port sets the servo, motor and imu register addresses.
// Sequence:
//   Each of the first three bytes is accepted, then the bit-serial CRC
//   unit shifts it in one bit per cycle; no byte is taken meanwhile.
//   The CRC byte is checked as it is taken; a good write frame then loads
//   its event into the output register once that is free, and a read
//   burst loads its items one after another, each once the register is
//   free.
// Reset: frame phase, CRC, shadows and the output valid flag clear; the
//   address registers return to 0, 1 and 2.
// Stall: a held result only blocks loading the next result; bytes are still
//   taken meanwhile, but none during a burst or while a write event waits
//   for the output register.
// ----------------------------------------------------------------------------
module crc_checked_register_frame_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    crcp_byte_if.sink                    i_rx,
    crcp_evt_if.source                   o_evt,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crcp_pkg::APB_AW-1:0]  paddr,
    input  logic [crcp_pkg::APB_DW-1:0]  pwdata,
    output logic [crcp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import crcp_pkg::*;

    t_cfg              w_cfg;
    t_crc_ctl          w_crc_ctl;
    logic [BYTE_W-1:0] w_crc;

    // configuration registers
    crcp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // serial crc unit, fed the first three bytes of each frame
    crcp_crc8_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .i_byte  (i_rx.rx_byte),
        .o_crc   (w_crc)
    );

    // frame sequencer
    crcp_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .rx        (i_rx),
        .evt       (o_evt),
        .o_crc_ctl (w_crc_ctl),
        .i_crc     (w_crc)
    );

    // no byte is taken while the crc unit is shifting
    a_no_accept_while_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx.ready |-> !w_crc_ctl.step)
        else $error("byte accepted during crc shift");

    // a crc shift always follows a captured frame byte or another shift
    a_shift_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crc_ctl.step |-> $past(w_crc_ctl.load || w_crc_ctl.step))
        else $error("crc shift without a loaded byte");

    // a write event is always the only result of its frame
    a_write_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && (o_evt.event_kind == EVT_WRITE)) |-> o_evt.last_of_run)
        else $error("write event not marked last");

    // read items carry a zero action code
    a_read_action_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && (o_evt.event_kind == EVT_READ)) |->
            (o_evt.write_action == ACT_SERVO))
        else $error("read item with nonzero action");
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-8 register frame parser. Bytes go in as
// 4-byte frames (directed rows first, then random well-formed, corrupted and
// junk frames) under several address maps written over APB. A bench-side
// parser predicts every write event and read burst item, and each result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import crcp_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned MAX_WAIT     = 16;
    localparam int unsigned DIR_ROWS     = 7;

    // register index past the end of the map, writes must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        AWAIT_HEADER,
        AWAIT_DATA_LO,
        AWAIT_DATA_HI,
        AWAIT_CRC
    } t_frame_phase;

    // one directed frame, with a typed-in result where it is obvious
    typedef struct {
        logic [7:0] hdr;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] crc_flip;
        bit         typed;
        bit         has_evt;
        t_evt       evt;
    } t_dir_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    crcp_byte_if rx_if ();
    crcp_evt_if  evt_if ();

    crc_checked_register_frame_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_evt   (evt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // bench copy of the parser state and address map
    t_cfg         addr_map;
    t_frame_phase fr_phase;
    logic [7:0]   fr_header;
    logic [7:0]   fr_lo;
    logic [7:0]   fr_hi;
    logic [7:0]   servo_cmd;
    logic [15:0]  motor_cmd;

    t_evt owed_events[$];
    t_evt step_events[$];
    t_evt typed_events[$];
    bit   use_typed     = 1'b0;
    bit   tx_quiet      = 1'b0;
    bit   rx_quiet      = 1'b0;
    bit   hold_request  = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    t_dir_row dir_rows[DIR_ROWS];

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // crc-8 atm over header, data low, data high, msb first
    function automatic logic [7:0] atm_crc8(input logic [7:0] h, input logic [7:0] l,
                                            input logic [7:0] d);
        logic [23:0] msg;
        logic [7:0]  crc;
        msg = {h, l, d};
        crc = '0;
        for (int n = 23; n >= 0; n--) begin
            if (crc[7] ^ msg[n])
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[6:0], 1'b0};
        end
        return crc;
    endfunction

    // advance the bench parser by one byte, results land in step_events
    task automatic decode_rx_byte(input logic [7:0] b);
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] a;
        int unsigned       count;
        t_evt              ev;
        step_events.delete();
        case (fr_phase)
            AWAIT_HEADER: begin
                fr_header = b;
                fr_phase  = AWAIT_DATA_LO;
            end
            AWAIT_DATA_LO: begin
                fr_lo    = b;
                fr_phase = AWAIT_DATA_HI;
            end
            AWAIT_DATA_HI: begin
                fr_hi    = b;
                fr_phase = AWAIT_CRC;
            end
            default: begin
                fr_phase = AWAIT_HEADER;
                if (atm_crc8(fr_header, fr_lo, fr_hi) == b) begin
                    base = fr_header[ADDR_W-1:0];
                    if (fr_header[7]) begin
                        // read burst, address wraps at 7 bits
                        count = (fr_lo > 8'(MAX_BURST)) ? MAX_BURST : 32'(fr_lo);
                        for (int unsigned i = 0; i < count; i++) begin
                            a = base + ADDR_W'(i);
                            ev.event_kind    = EVT_READ;
                            ev.reply_address = a;
                            if (a == addr_map.servo_addr)
                                ev.reply_value = {{8{servo_cmd[7]}}, servo_cmd};
                            else if (a == addr_map.motor_addr)
                                ev.reply_value = motor_cmd;
                            else
                                ev.reply_value = '0;
                            // action field is zero on read items
                            ev.write_action  = '0;
                            ev.last_of_run   = (i == count - 1);
                            step_events.push_back(ev);
                        end
                    end else begin
                        // write, servo wins over motor wins over imu
                        ev.event_kind    = EVT_WRITE;
                        ev.reply_address = base;
                        ev.reply_value   = {fr_hi, fr_lo};
                        ev.last_of_run   = 1'b1;
                        if (base == addr_map.servo_addr) begin
                            ev.write_action = ACT_SERVO;
                            servo_cmd       = fr_lo;
                        end else if (base == addr_map.motor_addr) begin
                            ev.write_action = ACT_MOTOR;
                            motor_cmd       = {fr_hi, fr_lo};
                        end else if (base == addr_map.imu_addr) begin
                            ev.write_action = ACT_IMU;
                        end else begin
                            ev.write_action = ACT_OTHER;
                        end
                        step_events.push_back(ev);
                    end
                end
            end
        endcase
    endtask

    // one byte transfer with a random lead-in gap
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if ($urandom_range(0, 7) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        decode_rx_byte(b);
        if (use_typed) begin
            foreach (typed_events[k]) owed_events.push_back(typed_events[k]);
            use_typed = 1'b0;
        end else begin
            foreach (step_events[k]) owed_events.push_back(step_events[k]);
        end
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] crc_flip,
                              input bit typed);
        send_byte(hdr);
        send_byte(lo);
        send_byte(hi);
        use_typed = typed;
        send_byte(atm_crc8(hdr, lo, hi) ^ crc_flip);
    endtask

    // drop valid, wait out every owed result, then let the block settle
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        while (owed_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SERVO: addr_map.servo_addr = data[ADDR_W-1:0];
            REG_MOTOR: addr_map.motor_addr = data[ADDR_W-1:0];
            REG_IMU:   addr_map.imu_addr   = data[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_read(input logic [1:0] idx);
        logic [APB_DW-1:0] want;
        case (idx)
            REG_SERVO: want = APB_DW'(addr_map.servo_addr);
            REG_MOTOR: want = APB_DW'(addr_map.motor_addr);
            default:   want = APB_DW'(addr_map.imu_addr);
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new address map, upper data bits random to exercise masking
    task automatic configure(input logic [6:0] servo, input logic [6:0] motor,
                             input logic [6:0] imu, input bit poke_spare);
        logic [APB_DW-1:0] noise;
        noise = $urandom();
        apb_write(REG_SERVO, {noise[APB_DW-1:ADDR_W], servo});
        noise = $urandom();
        apb_write(REG_MOTOR, {noise[APB_DW-1:ADDR_W], motor});
        noise = $urandom();
        apb_write(REG_IMU, {noise[APB_DW-1:ADDR_W], imu});
        if (poke_spare)
            apb_write(REG_SPARE, $urandom());
        apb_read(REG_SERVO);
        apb_read(REG_MOTOR);
        apb_read(REG_IMU);
    endtask

    // mostly good frames aimed at the mapped addresses, some corrupt or junk
    task automatic random_frames(input int unsigned n);
        int unsigned       pick;
        bit                is_read;
        logic [ADDR_W-1:0] base;
        logic [7:0]        lo;
        logic [7:0]        hi;
        logic [7:0]        flip;
        for (int unsigned f = 0; f < n; f++) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                repeat (4) send_byte(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 4))
                    0:       base = addr_map.servo_addr;
                    1:       base = addr_map.motor_addr;
                    2:       base = addr_map.imu_addr;
                    3:       base = addr_map.servo_addr - ADDR_W'($urandom_range(0, 3));
                    default: base = ADDR_W'($urandom_range(0, 127));
                endcase
                is_read = ($urandom_range(0, 9) < 4);
                hi      = 8'($urandom_range(0, 255));
                if (is_read)
                    lo = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(60, 255))
                                                      : 8'($urandom_range(0, 6));
                else
                    lo = 8'($urandom_range(0, 255));
                flip = (pick < 5) ? (8'h01 << $urandom_range(0, 7)) : 8'h00;
                send_frame({is_read, base}, lo, hi, flip, 1'b0);
            end
        end
    endtask

    // stimulus
    initial begin
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;

        addr_map  = '{servo_addr: 7'd0, motor_addr: 7'd1, imu_addr: 7'd2};
        fr_phase  = AWAIT_HEADER;
        fr_header = '0;
        fr_lo     = '0;
        fr_hi     = '0;
        servo_cmd = '0;
        motor_cmd = '0;

        // writes to each target, corrupt frame, empty read, wrapping saturated read
        dir_rows[0] = '{8'h00, 8'h80, 8'hFF, 8'h00, 1'b1, 1'b1,
                        t_evt'{EVT_WRITE, 7'h00, 16'hFF80, ACT_SERVO, 1'b1}};
        dir_rows[1] = '{8'h01, 8'h00, 8'h80, 8'h00, 1'b1, 1'b1,
                        t_evt'{EVT_WRITE, 7'h01, 16'h8000, ACT_MOTOR, 1'b1}};
        dir_rows[2] = '{8'h02, 8'hFF, 8'h7F, 8'h00, 1'b1, 1'b1,
                        t_evt'{EVT_WRITE, 7'h02, 16'h7FFF, ACT_IMU, 1'b1}};
        dir_rows[3] = '{8'h7F, 8'h55, 8'hAA, 8'h00, 1'b1, 1'b1,
                        t_evt'{EVT_WRITE, 7'h7F, 16'hAA55, ACT_OTHER, 1'b1}};
        dir_rows[4] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, t_evt'('0)};
        dir_rows[5] = '{8'h80, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, t_evt'('0)};
        dir_rows[6] = '{8'hFE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, t_evt'('0)};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under the reset address map
        foreach (dir_rows[r]) begin
            typed_events.delete();
            if (dir_rows[r].has_evt)
                typed_events.push_back(dir_rows[r].evt);
            send_frame(dir_rows[r].hdr, dir_rows[r].lo, dir_rows[r].hi,
                       dir_rows[r].crc_flip, dir_rows[r].typed);
        end
        wait_idle();

        // extremes of the map, plus a write past the last register
        configure(7'd127, 7'd0, 7'd64, 1'b1);
        random_frames(4);
        wait_idle();

        // all three on one address
        configure(7'd5, 7'd5, 7'd5, 1'b0);
        random_frames(4);
        wait_idle();

        // random map, with the result side held off for a long stretch
        configure(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)), 1'b0);
        hold_request = 1'b1;
        random_frames(7);
        wait_idle();

        configure(7'd0, 7'd127, 7'd127, 1'b0);
        random_frames(4);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off on request, field checks
    initial begin
        int unsigned stall;
        t_evt        want;
        evt_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                evt_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 7) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                evt_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            evt_if.ready <= 1'b1;
            do @(posedge i_clk); while (!evt_if.valid);
            if (owed_events.size() == 0) begin
                report_mismatch($sformatf("unowed result: kind %0d addr %0h value %0h",
                                          evt_if.event_kind, evt_if.reply_address,
                                          evt_if.reply_value));
            end else begin
                want = owed_events.pop_front();
                if (evt_if.event_kind    !== want.event_kind    ||
                    evt_if.reply_address !== want.reply_address ||
                    evt_if.reply_value   !== want.reply_value   ||
                    evt_if.write_action  !== want.write_action  ||
                    evt_if.last_of_run   !== want.last_of_run)
                    report_mismatch($sformatf(
                        "got kind %0d addr %0h value %0h act %0d last %0d, want %0d %0h %0h %0d %0d",
                        evt_if.event_kind, evt_if.reply_address, evt_if.reply_value,
                        evt_if.write_action, evt_if.last_of_run,
                        want.event_kind, want.reply_address, want.reply_value,
                        want.write_action, want.last_of_run));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
